>>> hw/rtl/ati_pkg.sv
// Shared types and constants of the adaptive trapezoid integrator.
`timescale 1ns / 1ps

package ati_pkg;

  // Number format and sizes
  localparam int DATA_W      = 64;
  localparam int FRAC_BITS   = 32;
  localparam int LEVEL_LIMIT = 30;
  localparam int LEVEL_W     = 5;
  localparam int COUNT_W     = 30;
  localparam int TOL_W       = 6;
  localparam int CHANGE_W    = DATA_W - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int HALF_W      = DATA_W / 2;
  localparam int PART_W      = 2 * (HALF_W + 1);
  localparam int PROD_W      = 2 * DATA_W;

  // Command codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Kind of beat travelling down the pipeline
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd3;

  // Register reset values: a = 1.0, b = 2.0
  localparam logic [DATA_W-1:0]  RESET_LOWER     = 64'h0000_0001_0000_0000;
  localparam logic [DATA_W-1:0]  RESET_UPPER     = 64'h0000_0002_0000_0000;
  localparam logic [DATA_W:0]    RESET_SPAN      = 65'h0_0000_0001_0000_0000;
  localparam logic [TOL_W-1:0]   RESET_TOL       = 6'd40;
  localparam logic [LEVEL_W-1:0] RESET_MAX_LEVEL = 5'd20;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration registers plus the span b - a kept alongside
  typedef struct packed {
    logic [DATA_W-1:0]  lower;
    logic [DATA_W-1:0]  upper;
    logic [DATA_W:0]    span;
    logic [TOL_W-1:0]   tol;
    logic [LEVEL_W-1:0] max_level;
  } cfg_t;

  // Per-beat control carried alongside the datapath
  typedef struct packed {
    logic [1:0]         kind;
    logic               end_point;
    logic               complete;
    logic               at_limit;
    logic [LEVEL_W-1:0] level;
    logic               req;
    logic [DATA_W-1:0]  point;
  } ctl_t;

  // Status from the back end to the sequencer
  typedef struct packed {
    logic level_busy;
    logic stop;
  } fb_t;

endpackage

>>> hw/rtl/ati_if.sv
// Channel interfaces: command input, result output and configuration writes.
`timescale 1ns / 1ps

interface ati_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [ati_pkg::DATA_W-1:0] sample_value;

  modport source (output valid, output operation, output sample_value, input ready);
  modport sink (input valid, input operation, input sample_value, output ready);
endinterface

interface ati_res_if;
  logic                                valid;
  logic                                ready;
  logic                                request_valid;
  logic signed [ati_pkg::DATA_W-1:0]   next_point;
  logic                                level_done;
  logic [ati_pkg::LEVEL_W-1:0]         level_reached;
  logic signed [ati_pkg::DATA_W-1:0]   estimate;
  logic [ati_pkg::CHANGE_W-1:0]        change;
  logic                                converged;
  logic                                finished;

  modport source (output valid, output request_valid, output next_point,
                  output level_done, output level_reached, output estimate,
                  output change, output converged, output finished, input ready);
  modport sink (input valid, input request_valid, input next_point,
                input level_done, input level_reached, input estimate,
                input change, input converged, input finished, output ready);
endinterface

interface ati_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ati_pkg::CFG_IDX_W-1:0]    index;
  logic [ati_pkg::DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ati_cfg.sv
// Configuration register file; keeps the span b - a updated on each bound write.
`timescale 1ns / 1ps

module ati_cfg (
  input  logic          clk,
  input  logic          rst,
  ati_cfg_if.sink       cfg,
  output ati_pkg::cfg_t regs
);

  logic [ati_pkg::DATA_W-1:0] wr_data;
  logic [ati_pkg::DATA_W:0]   wr_ext;
  logic [ati_pkg::DATA_W:0]   lower_ext;
  logic [ati_pkg::DATA_W:0]   upper_ext;

  assign cfg.ready = 1'b1;
  assign wr_data   = cfg.data;
  assign wr_ext    = {wr_data[ati_pkg::DATA_W-1], wr_data};
  assign lower_ext = {regs.lower[ati_pkg::DATA_W-1], regs.lower};
  assign upper_ext = {regs.upper[ati_pkg::DATA_W-1], regs.upper};

  // Take a write beat; the span follows whichever bound changed
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lower     <= ati_pkg::RESET_LOWER;
      regs.upper     <= ati_pkg::RESET_UPPER;
      regs.span      <= ati_pkg::RESET_SPAN;
      regs.tol       <= ati_pkg::RESET_TOL;
      regs.max_level <= ati_pkg::RESET_MAX_LEVEL;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ati_pkg::REG_LOWER: begin
          regs.lower <= wr_data;
          regs.span  <= upper_ext - wr_ext;
        end
        ati_pkg::REG_UPPER: begin
          regs.upper <= wr_data;
          regs.span  <= wr_ext - lower_ext;
        end
        ati_pkg::REG_TOL: begin
          regs.tol <= wr_data[ati_pkg::TOL_W-1:0];
        end
        ati_pkg::REG_MAX_LEVEL: begin
          regs.max_level <= wr_data[ati_pkg::LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/ati_ctl.sv
// Sequencer: level, phase and point bookkeeping at the input beat, plus the input register.
`timescale 1ns / 1ps

module ati_ctl (
  input  logic                       clk,
  input  logic                       rst,
  ati_cmd_if.sink                    cmd,
  input  ati_pkg::cfg_t              regs,
  input  ati_pkg::fb_t               fb,
  input  logic                       en2,
  output logic                       v1,
  output logic [ati_pkg::DATA_W-1:0] f1,
  output logic [ati_pkg::DATA_W-1:0] h1,
  output ati_pkg::ctl_t              ctl1
);

  // First-level phases
  localparam logic [1:0] PHASE_LOWER = 2'd0;
  localparam logic [1:0] PHASE_UPPER = 2'd1;
  localparam logic [1:0] PHASE_MID   = 2'd2;

  logic                        running;
  logic [ati_pkg::LEVEL_W-1:0] level;
  logic [ati_pkg::COUNT_W-1:0] points_left;
  logic [1:0]                  phase;
  logic                        take_left;
  logic [ati_pkg::DATA_W-1:0]  left_pos;
  logic [ati_pkg::DATA_W-1:0]  right_pos;

  logic                        running_next;
  logic [ati_pkg::LEVEL_W-1:0] level_next;
  logic [ati_pkg::COUNT_W-1:0] points_left_next;
  logic [1:0]                  phase_next;
  logic                        take_left_next;
  logic [ati_pkg::DATA_W-1:0]  left_pos_next;
  logic [ati_pkg::DATA_W-1:0]  right_pos_next;
  ati_pkg::ctl_t               ctl_next;

  logic signed [ati_pkg::DATA_W:0] span_shift;
  logic [ati_pkg::DATA_W-1:0]      h_cur;
  logic [ati_pkg::DATA_W-1:0]      h_nxt;
  logic [ati_pkg::DATA_W-1:0]      h_dbl;
  logic [ati_pkg::DATA_W-1:0]      first_left;
  logic [ati_pkg::LEVEL_W-1:0]     lim;
  logic                            at_limit;
  logic                            en1;
  logic                            accept;

  // Step for this level and the next one
  always_comb begin
    span_shift = $signed(regs.span) >>> level;
    h_cur      = span_shift[ati_pkg::DATA_W-1:0];
    h_nxt      = $signed(h_cur) >>> 1;
    h_dbl      = {h_cur[ati_pkg::DATA_W-2:0], 1'b0};
    first_left = regs.lower + h_nxt;
  end

  // Deepest level for this run
  always_comb begin
    if (regs.max_level < ati_pkg::LEVEL_W'(ati_pkg::LEVEL_LIMIT)) begin
      lim = regs.max_level;
    end else begin
      lim = ati_pkg::LEVEL_W'(ati_pkg::LEVEL_LIMIT);
    end
    if (lim == '0) begin
      lim = ati_pkg::LEVEL_W'(1);
    end
    at_limit = (level >= lim);
  end

  // Hold input on a stall, or while a level-closing beat waits for its convergence verdict
  assign en1       = !v1 || en2;
  assign cmd.ready = en1 && !fb.level_busy && !(v1 && ctl1.complete);
  assign accept    = cmd.valid && cmd.ready;

  // Next state and beat control
  always_comb begin
    running_next     = running;
    level_next       = level;
    points_left_next = points_left;
    phase_next       = phase;
    take_left_next   = take_left;
    left_pos_next    = left_pos;
    right_pos_next   = right_pos;
    ctl_next         = '0;
    ctl_next.kind    = ati_pkg::KIND_NONE;

    if (cmd.operation == ati_pkg::OP_START) begin
      running_next     = 1'b1;
      level_next       = ati_pkg::LEVEL_W'(1);
      phase_next       = PHASE_LOWER;
      points_left_next = '0;
      take_left_next   = 1'b1;
      ctl_next.kind    = ati_pkg::KIND_START;
      ctl_next.req     = 1'b1;
      ctl_next.point   = regs.lower;
    end else if (running) begin
      ctl_next.kind  = ati_pkg::KIND_SAMPLE;
      ctl_next.level = level;
      if (level == ati_pkg::LEVEL_W'(1)) begin
        case (phase)
          PHASE_LOWER: begin
            ctl_next.end_point = 1'b1;
            phase_next         = PHASE_UPPER;
            ctl_next.req       = 1'b1;
            ctl_next.point     = regs.upper;
          end
          PHASE_UPPER: begin
            ctl_next.end_point = 1'b1;
            phase_next         = PHASE_MID;
            ctl_next.req       = 1'b1;
            ctl_next.point     = regs.lower + h_cur;
          end
          default: begin
            ctl_next.complete = 1'b1;
          end
        endcase
      end else begin
        // Walk inward from both ends, alternating
        if (take_left) begin
          left_pos_next = left_pos + h_dbl;
        end else begin
          right_pos_next = right_pos - h_dbl;
        end
        take_left_next   = !take_left;
        points_left_next = points_left - ati_pkg::COUNT_W'(1);
        if (points_left_next == '0) begin
          ctl_next.complete = 1'b1;
        end else begin
          ctl_next.req   = 1'b1;
          ctl_next.point = take_left ? right_pos : left_pos;
        end
      end

      // Close the level; open the next one unless at the limit
      if (ctl_next.complete) begin
        ctl_next.at_limit = at_limit;
        if (at_limit) begin
          running_next = 1'b0;
        end else begin
          level_next       = level + ati_pkg::LEVEL_W'(1);
          left_pos_next    = first_left;
          right_pos_next   = regs.upper - h_nxt;
          points_left_next = ati_pkg::COUNT_W'(1) << level;
          take_left_next   = 1'b1;
          ctl_next.req     = 1'b1;
          ctl_next.point   = first_left;
        end
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      level       <= '0;
      points_left <= '0;
      phase       <= PHASE_LOWER;
      take_left   <= 1'b1;
      left_pos    <= '0;
      right_pos   <= '0;
      v1          <= 1'b0;
    end else begin
      if (accept) begin
        running     <= running_next;
        level       <= level_next;
        points_left <= points_left_next;
        phase       <= phase_next;
        take_left   <= take_left_next;
        left_pos    <= left_pos_next;
        right_pos   <= right_pos_next;
      end else if (fb.stop) begin
        running <= 1'b0;
      end
      if (en1) begin
        v1 <= accept;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      f1   <= cmd.sample_value;
      h1   <= h_cur;
      ctl1 <= ctl_next;
    end
  end

endmodule

>>> hw/rtl/ati_term.sv
// Term pipeline: h times f from 33x33 partial products, scaled and saturated.
`timescale 1ns / 1ps

module ati_term (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       v1,
  input  logic [ati_pkg::DATA_W-1:0] f1,
  input  logic [ati_pkg::DATA_W-1:0] h1,
  input  ati_pkg::ctl_t              ctl1,
  input  logic                       en5,
  output logic                       en2,
  output logic                       v4,
  output logic [ati_pkg::DATA_W-1:0] term4,
  output ati_pkg::ctl_t              ctl4,
  output logic                       busy
);

  localparam int HW = ati_pkg::HALF_W;
  localparam int DW = ati_pkg::DATA_W;
  localparam int PW = ati_pkg::PART_W;
  localparam int QW = ati_pkg::PROD_W;

  logic signed [HW:0] h_lo, h_hi, f_lo, f_hi;

  logic                 v2, v3;
  logic                 en3, en4;
  ati_pkg::ctl_t        ctl2, ctl3;
  logic signed [PW-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [QW-1:0]        prod_sum;
  logic [QW-1:0]        prod3;
  logic signed [QW-1:0] prod_shift;
  logic                 fits;
  logic [DW-1:0]        term_sat;

  // Split operands into signed 33-bit halves
  assign h_lo = $signed({1'b0, h1[HW-1:0]});
  assign h_hi = $signed({h1[DW-1], h1[DW-1:HW]});
  assign f_lo = $signed({1'b0, f1[HW-1:0]});
  assign f_hi = $signed({f1[DW-1], f1[DW-1:HW]});

  // Combine the partial products into the full product
  assign prod_sum = {{(QW-PW){pp_ll[PW-1]}}, pp_ll}
                  + ({{(QW-PW){pp_lh[PW-1]}}, pp_lh} << HW)
                  + ({{(QW-PW){pp_hl[PW-1]}}, pp_hl} << HW)
                  + ({{(QW-PW){pp_hh[PW-1]}}, pp_hh} << DW);

  // Scale toward minus infinity; end points take one extra halving
  always_comb begin
    if (ctl3.end_point) begin
      prod_shift = $signed(prod3) >>> (ati_pkg::FRAC_BITS + 1);
    end else begin
      prod_shift = $signed(prod3) >>> ati_pkg::FRAC_BITS;
    end
    fits = (&prod_shift[QW-1:DW-1]) || !(|prod_shift[QW-1:DW-1]);
    if (fits) begin
      term_sat = prod_shift[DW-1:0];
    end else if (prod_shift[QW-1]) begin
      term_sat = ati_pkg::SAT_MIN;
    end else begin
      term_sat = ati_pkg::SAT_MAX;
    end
  end

  // Stage enables: a stage advances when empty or when its successor moves
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;

  assign busy = (v2 && ctl2.complete) || (v3 && ctl3.complete) || (v4 && ctl4.complete);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en2) begin
      pp_ll <= h_lo * f_lo;
      pp_lh <= h_lo * f_hi;
      pp_hl <= h_hi * f_lo;
      pp_hh <= h_hi * f_hi;
      ctl2  <= ctl1;
    end
    if (en3) begin
      prod3 <= prod_sum;
      ctl3  <= ctl2;
    end
    if (en4) begin
      term4 <= term_sat;
      ctl4  <= ctl3;
    end
  end

endmodule

>>> hw/rtl/ati_acc.sv
// Back end: saturating accumulate, change and tolerance check, result register.
`timescale 1ns / 1ps

module ati_acc (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       v4,
  input  logic [ati_pkg::DATA_W-1:0] term4,
  input  ati_pkg::ctl_t              ctl4,
  input  logic [ati_pkg::TOL_W-1:0]  tol,
  ati_res_if.source                  result,
  output logic                       en5,
  output ati_pkg::fb_t               fb
);

  localparam int DW = ati_pkg::DATA_W;
  localparam int CW = ati_pkg::CHANGE_W;

  logic [DW-1:0] sum;
  logic [DW-1:0] prev;
  logic [DW-1:0] sum_raw;
  logic [DW-1:0] sum_sat;

  logic          v5, v6, v7;
  logic          en6, en7;
  ati_pkg::ctl_t ctl5, ctl6;
  logic [DW-1:0] est5, prev5, est6, mag6;
  logic [CW-1:0] chg6;

  logic [DW:0]   diff_a, diff_b;
  logic [DW-1:0] dmag;
  logic [CW-1:0] chg_sat;
  logic [DW-1:0] mag;
  logic [DW-1:0] bound;
  logic          conv;
  logic          done;
  logic          req;

  // Saturating add of the new term
  always_comb begin
    sum_raw = sum + term4;
    if (!sum[DW-1] && !term4[DW-1] && sum_raw[DW-1]) begin
      sum_sat = ati_pkg::SAT_MAX;
    end else if (sum[DW-1] && term4[DW-1] && !sum_raw[DW-1]) begin
      sum_sat = ati_pkg::SAT_MIN;
    end else begin
      sum_sat = sum_raw;
    end
  end

  // Change magnitude, clamped, and magnitude of the estimate
  always_comb begin
    diff_a  = {est5[DW-1], est5} - {prev5[DW-1], prev5};
    diff_b  = {prev5[DW-1], prev5} - {est5[DW-1], est5};
    dmag    = diff_a[DW] ? diff_b[DW-1:0] : diff_a[DW-1:0];
    chg_sat = dmag[DW-1] ? {CW{1'b1}} : dmag[CW-1:0];
    mag     = est5[DW-1] ? (~est5 + DW'(1)) : est5;
  end

  // Verdict and result fields
  always_comb begin
    bound = mag6 >> tol;
    conv  = {1'b0, chg6} <= bound;
    done  = ctl6.complete;
    req   = ctl6.req && !(done && conv);
  end

  assign en7 = !v7 || result.ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;

  assign fb.stop       = v6 && en7 && ctl6.complete && conv;
  assign fb.level_busy = (v5 && ctl5.complete) || (v6 && ctl6.complete);

  assign result.valid = v7;

  // Running and previous sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      prev <= '0;
    end else if (v4 && en5) begin
      case (ctl4.kind)
        ati_pkg::KIND_START: begin
          sum  <= '0;
          prev <= '0;
        end
        ati_pkg::KIND_SAMPLE: begin
          if (ctl4.complete) begin
            prev <= sum_sat;
            sum  <= $signed(sum_sat) >>> 1;
          end else begin
            sum <= sum_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // Advance payload; drop fields that carry no meaning
  always_ff @(posedge clk) begin
    if (en5) begin
      est5  <= sum_sat;
      prev5 <= prev;
      ctl5  <= ctl4;
    end
    if (en6) begin
      est6 <= est5;
      mag6 <= mag;
      chg6 <= chg_sat;
      ctl6 <= ctl5;
    end
    if (en7) begin
      result.request_valid <= req;
      result.next_point    <= req ? ctl6.point : '0;
      result.level_done    <= done;
      result.level_reached <= done ? ctl6.level : '0;
      result.estimate      <= done ? est6 : '0;
      result.change        <= done ? chg6 : '0;
      result.converged     <= done && conv;
      result.finished      <= done && (conv || ctl6.at_limit);
    end
  end

endmodule

>>> hw/rtl/adaptive_trapezoid_integrator.sv
// Successive-halving trapezoid integrator: top level.
// Each beat passes the input, term and accumulate stages to the result channel.
// Throughput: one beat per cycle while results are taken; after a beat that closes
// a level the command channel holds off until that beat's verdict is registered.
// Reset (rst, synchronous): no run active, pipeline empty, registers a=1.0, b=2.0,
// tolerance exponent 40, max level 20.
`timescale 1ns / 1ps

module adaptive_trapezoid_integrator (
  input  logic      clk,
  input  logic      rst,
  ati_cmd_if.sink   cmd,
  ati_res_if.source result,
  ati_cfg_if.sink   cfg
);

  ati_pkg::cfg_t              regs;
  ati_pkg::fb_t               fb;
  ati_pkg::fb_t               fb_acc;
  logic                       term_busy;

  logic                       en2;
  logic                       en5;
  logic                       v1;
  logic [ati_pkg::DATA_W-1:0] f1;
  logic [ati_pkg::DATA_W-1:0] h1;
  ati_pkg::ctl_t              ctl1;
  logic                       v4;
  logic [ati_pkg::DATA_W-1:0] term4;
  ati_pkg::ctl_t              ctl4;

  // Merge level-busy status from both pipeline sections
  assign fb.level_busy = term_busy || fb_acc.level_busy;
  assign fb.stop       = fb_acc.stop;

  ati_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ati_ctl u_ctl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .regs (regs),
    .fb   (fb),
    .en2  (en2),
    .v1   (v1),
    .f1   (f1),
    .h1   (h1),
    .ctl1 (ctl1)
  );

  ati_term u_term (
    .clk   (clk),
    .rst   (rst),
    .v1    (v1),
    .f1    (f1),
    .h1    (h1),
    .ctl1  (ctl1),
    .en5   (en5),
    .en2   (en2),
    .v4    (v4),
    .term4 (term4),
    .ctl4  (ctl4),
    .busy  (term_busy)
  );

  ati_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .v4     (v4),
    .term4  (term4),
    .ctl4   (ctl4),
    .tol    (regs.tol),
    .result (result),
    .en5    (en5),
    .fb     (fb_acc)
  );

endmodule

>>> sim/tb_adaptive_trapezoid_integrator.sv
// Testbench for the adaptive trapezoid integrator: directed and random runs, scoreboarded.
`timescale 1ns / 1ps

module tb_adaptive_trapezoid_integrator;
  import ati_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 85;
  localparam int PRINT_LIMIT = 40;

  // Integrand shapes fed back for each requested point
  typedef enum int {SHAPE_FLAT, SHAPE_RAMP, SHAPE_BOWL, SHAPE_NOISE, SHAPE_EDGE} shape_t;

  // One result beat as the block should produce it
  typedef struct packed {
    logic              req;
    logic [DATA_W-1:0] point;
    logic              done;
    logic [LEVEL_W-1:0] reached;
    logic [DATA_W-1:0] est;
    logic [CHANGE_W-1:0] chg;
    logic              conv;
    logic              fin;
  } level_report_t;

  // One command beat with the report it must cause
  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] value;
    level_report_t     want;
  } cmd_beat_t;

  logic clk;
  logic rst;

  ati_cmd_if cmd_ch();
  ati_res_if res_ch();
  ati_cfg_if cfg_ch();

  adaptive_trapezoid_integrator dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  cmd_beat_t     command_backlog[$];
  level_report_t awaited_reports[$];

  int error_count   = 0;
  int reports_seen  = 0;
  int items_queued  = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 58;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Integrator shadow: registers and run state
  logic signed [DATA_W-1:0] lo_bound, hi_bound;
  logic [TOL_W-1:0]         tol_exp;
  logic [LEVEL_W-1:0]       level_cap;
  logic                     run_active, left_turn;
  logic [LEVEL_W-1:0]       cur_level;
  logic [COUNT_W-1:0]       pts_remaining;
  logic [1:0]               edge_phase;
  logic signed [DATA_W-1:0] left_x, right_x, acc_sum, prior_sum;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] x,
                                                       input logic signed [DATA_W-1:0] y);
    logic [DATA_W:0] s;
    s = {x[DATA_W-1], x} + {y[DATA_W-1], y};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SAT_MIN : SAT_MAX;
    return s[DATA_W-1:0];
  endfunction

  // floor(h * f / 2^shift), saturated to the data range
  function automatic logic signed [DATA_W-1:0] scaled_product(
      input logic signed [DATA_W-1:0] h, input logic signed [DATA_W-1:0] f, input int shift);
    logic [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0] q;
    prod = {{DATA_W{h[DATA_W-1]}}, h} * {{DATA_W{f[DATA_W-1]}}, f};
    q = $signed(prod) >>> shift;
    if (q[PROD_W-1:DATA_W-1] == {(DATA_W+1){q[PROD_W-1]}}) return q[DATA_W-1:0];
    return q[PROD_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // floor((b - a) / 2^level)
  function automatic logic signed [DATA_W-1:0] step_size();
    logic signed [DATA_W:0]   span;
    logic signed [DATA_W-1:0] half;
    span = {hi_bound[DATA_W-1], hi_bound} - {lo_bound[DATA_W-1], lo_bound};
    half = span[DATA_W:1];
    return half >>> (cur_level - 5'd1);
  endfunction

  task automatic reset_shadow();
    lo_bound      = RESET_LOWER;
    hi_bound      = RESET_UPPER;
    tol_exp       = RESET_TOL;
    level_cap     = RESET_MAX_LEVEL;
    run_active    = 1'b0;
    left_turn     = 1'b1;
    cur_level     = '0;
    pts_remaining = '0;
    edge_phase    = '0;
    left_x        = '0;
    right_x       = '0;
    acc_sum       = '0;
    prior_sum     = '0;
  endtask

  // Advance the shadow by one command and return the report it causes
  function automatic level_report_t integrate_step(input logic op,
                                                   input logic signed [DATA_W-1:0] value);
    level_report_t            r;
    logic signed [DATA_W-1:0] h;
    logic [DATA_W-1:0]        gap, mag;
    logic [LEVEL_W-1:0]       stop_at;
    logic                     closed;
    r = '0;
    closed = 1'b0;
    if (op == OP_START) begin
      run_active    = 1'b1;
      cur_level     = 5'd1;
      edge_phase    = 2'd0;
      pts_remaining = '0;
      left_turn     = 1'b1;
      acc_sum       = '0;
      prior_sum     = '0;
      r.req         = 1'b1;
      r.point       = lo_bound;
    end else if (run_active) begin
      h = step_size();
      if (cur_level == 5'd1) begin
        // end points carry half weight, then the midpoint
        case (edge_phase)
          2'd0: begin
            acc_sum    = scaled_product(h, value, FRAC_BITS + 1);
            edge_phase = 2'd1;
            r.req      = 1'b1;
            r.point    = hi_bound;
          end
          2'd1: begin
            acc_sum    = sat_add(acc_sum, scaled_product(h, value, FRAC_BITS + 1));
            edge_phase = 2'd2;
            r.req      = 1'b1;
            r.point    = lo_bound + h;
          end
          default: begin
            acc_sum = sat_add(acc_sum, scaled_product(h, value, FRAC_BITS));
            closed  = 1'b1;
          end
        endcase
      end else begin
        // new midpoints alternate between the two ends
        acc_sum = sat_add(acc_sum, scaled_product(h, value, FRAC_BITS));
        if (left_turn) left_x = left_x + (h + h);
        else right_x = right_x - (h + h);
        left_turn = !left_turn;
        pts_remaining = pts_remaining - 1'b1;
        if (pts_remaining == '0) begin
          closed = 1'b1;
        end else begin
          r.req   = 1'b1;
          r.point = left_turn ? left_x : right_x;
        end
      end
      if (closed) begin
        stop_at = (level_cap < LEVEL_LIMIT) ? level_cap : LEVEL_W'(LEVEL_LIMIT);
        if (stop_at == '0) stop_at = 5'd1;
        gap = (acc_sum >= prior_sum) ? acc_sum - prior_sum : prior_sum - acc_sum;
        if (gap > SAT_MAX) gap = SAT_MAX;
        mag = acc_sum[DATA_W-1] ? (~acc_sum + 1'b1) : acc_sum;
        r.done    = 1'b1;
        r.reached = cur_level;
        r.est     = acc_sum;
        r.chg     = gap[CHANGE_W-1:0];
        r.conv    = gap <= (mag >> tol_exp);
        r.fin     = r.conv || cur_level >= stop_at;
        if (r.fin) begin
          run_active = 1'b0;
        end else begin
          // halve the sum and open the next level
          prior_sum     = acc_sum;
          acc_sum       = acc_sum >>> 1;
          cur_level     = cur_level + 5'd1;
          h             = step_size();
          left_x        = lo_bound + h;
          right_x       = hi_bound - h;
          pts_remaining = 30'd1 << (cur_level - 5'd1);
          left_turn     = 1'b1;
          r.req         = 1'b1;
          r.point       = left_x;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_command(input logic op, input logic [DATA_W-1:0] value,
                               output level_report_t r);
    cmd_beat_t beat;
    r = integrate_step(op, value);
    beat.op    = op;
    beat.value = value;
    beat.want  = r;
    command_backlog.push_back(beat);
    items_queued++;
  endtask

  function automatic logic [DATA_W-1:0] integrand(input shape_t shape,
                                                  input logic signed [DATA_W-1:0] x,
                                                  input logic signed [DATA_W-1:0] lift);
    logic signed [DATA_W-1:0] sq;
    sq = x >>> 16;
    case (shape)
      SHAPE_FLAT:  return lift;
      SHAPE_RAMP:  return x + lift;
      SHAPE_BOWL:  return sq * sq + lift;
      SHAPE_NOISE: return rand64();
      default: begin
        case ($urandom_range(4))
          0:       return SAT_MIN;
          1:       return SAT_MAX;
          2:       return '0;
          3:       return '1;
          default: return 64'd1;
        endcase
      end
    endcase
  endfunction

  // One run: start, then answer every request until it finishes or is cut short
  task automatic queue_run();
    shape_t                   shape;
    logic signed [DATA_W-1:0] lift;
    level_report_t            r;
    int                       count, early_stop;
    shape = shape_t'($urandom_range(0, 4));
    lift  = $signed(rand64()) >>> 28;
    if ($urandom_range(9) == 0) early_stop = $urandom_range(1, 20);
    else if (level_cap >= 5'd8) early_stop = $urandom_range(20, 70);
    else early_stop = -1;
    queue_command(OP_START, rand64(), r);
    count = 0;
    while (r.req && count != early_stop) begin
      queue_command(OP_SAMPLE, integrand(shape, r.point, lift), r);
      count++;
    end
    if (!r.req && $urandom_range(9) == 0) queue_command(OP_SAMPLE, rand64(), r);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_LOWER:     lo_bound  = data;
      REG_UPPER:     hi_bound  = data;
      REG_TOL:       tol_exp   = data[TOL_W-1:0];
      REG_MAX_LEVEL: level_cap = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every beat has gone through, then let the pipeline settle
  task automatic wait_idle();
    while (command_backlog.size() != 0 || awaited_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_phase(input int phase);
    logic signed [DATA_W-1:0] a, span;
    logic [DATA_W-1:0]        junk;
    logic [TOL_W-1:0]         tol;
    logic [LEVEL_W-1:0]       cap;
    a    = $signed(rand64()) >>> 28;
    span = (rand64() >> 30) + 1;
    case ($urandom_range(9))
      0: begin
        write_register(REG_LOWER, rand64());
        write_register(REG_UPPER, rand64());
      end
      1: begin
        write_register(REG_LOWER, a);
        write_register(REG_UPPER, a);
      end
      2, 3: begin
        write_register(REG_LOWER, a);
        write_register(REG_UPPER, a - span);
      end
      default: begin
        write_register(REG_LOWER, a);
        write_register(REG_UPPER, a + span);
      end
    endcase
    case ($urandom_range(3))
      0:       tol = 6'd0;
      1:       tol = 6'd63;
      2:       tol = TOL_W'($urandom_range(1, 12));
      default: tol = TOL_W'($urandom_range(0, 63));
    endcase
    case (phase)
      3:       cap = 5'd1;
      5:       cap = 5'd30;
      10:      cap = 5'd31;
      default: cap = LEVEL_W'($urandom_range(0, 7));
    endcase
    junk = rand64();
    write_register(REG_TOL, {junk[DATA_W-1:TOL_W], tol});
    junk = rand64();
    write_register(REG_MAX_LEVEL, {junk[DATA_W-1:LEVEL_W], cap});
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %h want %h", reports_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Command driver: present the oldest backlog beat, hold it until taken
  always @(posedge clk) begin : cmd_driver
    cmd_beat_t sent;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sent = command_backlog.pop_front();
        awaited_reports.push_back(sent.want);
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_ch.valid        <= 1'b1;
          cmd_ch.operation    <= command_backlog[0].op;
          cmd_ch.sample_value <= command_backlog[0].value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: compare each beat with the oldest awaited report
  always @(posedge clk) begin : result_monitor
    level_report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("beat with nothing outstanding", res_ch.estimate, '0);
      end else begin
        want = awaited_reports.pop_front();
        check_field("request_valid", res_ch.request_valid, want.req);
        check_field("next_point", res_ch.next_point, want.point);
        check_field("level_done", res_ch.level_done, want.done);
        check_field("level_reached", res_ch.level_reached, want.reached);
        check_field("estimate", res_ch.estimate, want.est);
        check_field("change", res_ch.change, want.chg);
        check_field("converged", res_ch.converged, want.conv);
        check_field("finished", res_ch.finished, want.fin);
      end
      reports_seen++;
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    level_report_t r;
    logic [DATA_W-1:0] junk;
    int phase_start;
    rst = 1'b1;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_LOWER;
    cfg_ch.data         <= '0;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle sample, all-zero run, saturating run cut short
    @(negedge clk);
    queue_command(OP_SAMPLE, SAT_MAX, r);
    queue_command(OP_START, SAT_MIN, r);
    repeat (3) queue_command(OP_SAMPLE, '0, r);
    queue_command(OP_SAMPLE, SAT_MIN, r);
    queue_command(OP_START, '0, r);
    queue_command(OP_SAMPLE, SAT_MAX, r);
    queue_command(OP_SAMPLE, SAT_MIN, r);
    queue_command(OP_SAMPLE, SAT_MAX, r);
    queue_command(OP_SAMPLE, 64'd1, r);
    queue_command(OP_SAMPLE, '1, r);
    queue_command(OP_SAMPLE, '0, r);
    queue_command(OP_START, rand64(), r);
    wait_idle();

    // Widest bounds, tightest tolerance, level cap of zero: sum and change saturate
    write_register(REG_LOWER, SAT_MIN);
    write_register(REG_UPPER, SAT_MAX);
    junk = rand64();
    write_register(REG_TOL, {junk[DATA_W-1:TOL_W], 6'd63});
    junk = rand64();
    write_register(REG_MAX_LEVEL, {junk[DATA_W-1:LEVEL_W], 5'd0});
    @(negedge clk);
    queue_command(OP_START, '0, r);
    repeat (3) queue_command(OP_SAMPLE, SAT_MIN, r);
    queue_command(OP_START, '0, r);
    repeat (3) queue_command(OP_SAMPLE, SAT_MAX, r);
    wait_idle();

    // Equal bounds: zero step, zero sum
    write_register(REG_LOWER, -64'sh3_0000_0000);
    write_register(REG_UPPER, -64'sh3_0000_0000);
    write_register(REG_TOL, 64'd0);
    write_register(REG_MAX_LEVEL, 64'd31);
    @(negedge clk);
    queue_command(OP_START, '0, r);
    queue_command(OP_SAMPLE, SAT_MAX, r);
    queue_command(OP_SAMPLE, SAT_MIN, r);
    queue_command(OP_SAMPLE, 64'd7, r);
    wait_idle();

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 35;
        recv_idle_pct = 58;
      end else if (phase < 8) begin
        send_idle_pct = 58;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_phase(phase);
      if (phase == 1 || phase == 9) hold_asked++;
      @(negedge clk);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) queue_run();
      wait_idle();
    end

    if (error_count == 0 && awaited_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ati_pkg.sv
hw/rtl/ati_if.sv
hw/rtl/ati_cfg.sv
hw/rtl/ati_ctl.sv
hw/rtl/ati_term.sv
hw/rtl/ati_acc.sv
hw/rtl/adaptive_trapezoid_integrator.sv
sim/tb_adaptive_trapezoid_integrator.sv
